>>> rtl/sorted_key_table_macros.svh
// Assertion helpers used by skt_dpath.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SKT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the trigger holds, the expectation must hold in the following cycle.
`define SKT_ASSERT_NEXT(label, trig, expect_next, msg) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (trig) |=> (expect_next)) else $error(msg);

`endif

>>> rtl/skt_pkg.sv
package skt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int HANDLE_BITS = 16;

   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_BITS    = 32;
   localparam int ENTRY_BITS  = KEY_BITS + HANDLE_BITS;

   localparam int KIND_BITS   = 2;
   localparam int HIN_BITS    = 16;
   localparam int POS_BITS    = 10;
   localparam int STATUS_BITS = 2;
   localparam int INDEX_BITS  = 10;
   localparam int HOUT_BITS   = 16;

   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_MISS  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_S_ADDR,
      ST_S_CMP,
      ST_SH_RD,
      ST_SH_WR,
      ST_INS_WR,
      ST_POS_RD,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      RES_FULL,
      RES_MISS,
      RES_RANGE,
      RES_FOUND,
      RES_INSERTED,
      RES_READ
   } res_kind_type;

   typedef struct packed {
      logic         req_ready;
      logic         srch_rd;
      logic         srch_step;
      logic         sh_rd;
      logic         sh_wr;
      logic         ins_wr;
      logic         pos_rd;
      logic         res_load;
      res_kind_type res_kind;
   } cmd_type;

   typedef struct packed {
      logic                 req_valid;
      logic [KIND_BITS-1:0] kind;
      logic                 full;
      logic                 pos_ok;
      logic                 live;
      logic                 key_eq;
      logic                 key_gt;
      logic                 sh_live;
      logic                 out_free;
   } stat_type;

endpackage

>>> rtl/skt_req_if.sv
interface skt_req_if;
   logic                          valid;
   logic                          ready;
   logic [skt_pkg::KIND_BITS-1:0] kind;
   logic [skt_pkg::KEY_BITS-1:0]  key;
   logic [skt_pkg::HIN_BITS-1:0]  handle;
   logic [skt_pkg::POS_BITS-1:0]  position;

   modport source (output valid, kind, key, handle, position, input ready);
   modport sink   (input valid, kind, key, handle, position, output ready);
endinterface

>>> rtl/skt_rsp_if.sv
interface skt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [skt_pkg::STATUS_BITS-1:0] status;
   logic [skt_pkg::INDEX_BITS-1:0]  index;
   logic [skt_pkg::HOUT_BITS-1:0]   handle_out;

   modport source (output valid, status, index, handle_out, input ready);
   modport sink   (input valid, status, index, handle_out, output ready);
endinterface

>>> rtl/skt_dpath.sv
`include "sorted_key_table_macros.svh"

module skt_dpath (
   input  logic               clock,
   input  logic               reset,
   skt_req_if.sink            req_ch,
   skt_rsp_if.source          rsp_ch,
   input  skt_pkg::cmd_type   cmd,
   output skt_pkg::stat_type  stat
);

   logic [skt_pkg::ENTRY_BITS-1:0] store_ff [skt_pkg::TABLE_DEPTH];
   logic [skt_pkg::ENTRY_BITS-1:0] rd_data_ff;

   logic [skt_pkg::KIND_BITS-1:0]   kind_ff;
   logic [skt_pkg::KEY_BITS-1:0]    key_ff;
   logic [skt_pkg::HANDLE_BITS-1:0] handle_ff;
   logic [skt_pkg::POS_BITS-1:0]    pos_ff;

   logic [skt_pkg::COUNT_BITS-1:0] count_ff;
   logic [skt_pkg::COUNT_BITS-1:0] lo_ff, lo_in;
   logic [skt_pkg::COUNT_BITS-1:0] hi1_ff, hi1_in;   // upper search bound plus one
   logic [skt_pkg::COUNT_BITS-1:0] sh_ff, sh_in;     // slot being filled by the shift
   logic [skt_pkg::ADDR_BITS-1:0]  mid_ff;

   logic                             rsp_valid_ff;
   logic [skt_pkg::STATUS_BITS-1:0]  status_ff, status_in;
   logic [skt_pkg::INDEX_BITS-1:0]   index_ff, index_in;
   logic [skt_pkg::HOUT_BITS-1:0]    hout_ff, hout_in;

   logic                             capture;
   logic [skt_pkg::COUNT_BITS:0]     span_sum;
   logic [skt_pkg::ADDR_BITS-1:0]    mid_next;
   logic [skt_pkg::KEY_BITS-1:0]     rd_key;
   logic [skt_pkg::HANDLE_BITS-1:0]  rd_handle;
   logic                             rd_en;
   logic [skt_pkg::ADDR_BITS-1:0]    rd_addr;
   logic                             wr_en;
   logic [skt_pkg::ADDR_BITS-1:0]    wr_addr;
   logic [skt_pkg::ENTRY_BITS-1:0]   wr_data;

   assign req_ch.ready = cmd.req_ready;
   assign capture      = req_ch.valid & cmd.req_ready;

   assign span_sum = {1'b0, lo_ff} + {1'b0, hi1_ff} - (skt_pkg::COUNT_BITS + 1)'(1);
   assign mid_next = skt_pkg::ADDR_BITS'(span_sum[skt_pkg::COUNT_BITS:1]);

   assign rd_key    = rd_data_ff[skt_pkg::ENTRY_BITS-1:skt_pkg::HANDLE_BITS];
   assign rd_handle = rd_data_ff[skt_pkg::HANDLE_BITS-1:0];

   // Table memory: one read and one write port, registered read data
   always_comb begin
      rd_en   = cmd.srch_rd | cmd.sh_rd | cmd.pos_rd;
      rd_addr = mid_next;
      if (cmd.sh_rd) begin
         rd_addr = skt_pkg::ADDR_BITS'(sh_ff - skt_pkg::COUNT_BITS'(1));
      end else if (cmd.pos_rd) begin
         rd_addr = skt_pkg::ADDR_BITS'(pos_ff);
      end
      wr_en   = cmd.sh_wr | cmd.ins_wr;
      wr_addr = skt_pkg::ADDR_BITS'(sh_ff);
      wr_data = rd_data_ff;
      if (cmd.ins_wr) begin
         wr_addr = skt_pkg::ADDR_BITS'(lo_ff);
         wr_data = {key_ff, handle_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // Search and shift bounds
   always_comb begin
      lo_in  = lo_ff;
      hi1_in = hi1_ff;
      sh_in  = sh_ff;
      if (capture) begin
         lo_in  = '0;
         hi1_in = count_ff;
         sh_in  = count_ff;
      end else if (cmd.srch_step) begin
         if (rd_key > key_ff) begin
            hi1_in = skt_pkg::COUNT_BITS'(mid_ff);
         end else begin
            lo_in = skt_pkg::COUNT_BITS'(mid_ff) + skt_pkg::COUNT_BITS'(1);
         end
      end else if (cmd.sh_wr) begin
         sh_in = sh_ff - skt_pkg::COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi1_ff <= hi1_in;
      sh_ff  <= sh_in;
      if (cmd.srch_rd) begin
         mid_ff <= mid_next;
      end
      if (capture) begin
         kind_ff   <= req_ch.kind;
         key_ff    <= req_ch.key;
         handle_ff <= skt_pkg::HANDLE_BITS'(req_ch.handle);
         pos_ff    <= req_ch.position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_wr) begin
         count_ff <= count_ff + skt_pkg::COUNT_BITS'(1);
      end
   end

   // Result register
   always_comb begin
      status_in = skt_pkg::STATUS_MISS;
      index_in  = '0;
      hout_in   = '0;
      unique case (cmd.res_kind)
         skt_pkg::RES_FULL:  status_in = skt_pkg::STATUS_FULL;
         skt_pkg::RES_MISS:  status_in = skt_pkg::STATUS_MISS;
         skt_pkg::RES_RANGE: status_in = skt_pkg::STATUS_RANGE;
         skt_pkg::RES_FOUND: begin
            status_in = skt_pkg::STATUS_OK;
            index_in  = skt_pkg::INDEX_BITS'(mid_ff);
            hout_in   = skt_pkg::HOUT_BITS'(rd_handle);
         end
         skt_pkg::RES_INSERTED: begin
            status_in = skt_pkg::STATUS_OK;
            index_in  = skt_pkg::INDEX_BITS'(lo_ff);
         end
         skt_pkg::RES_READ: begin
            status_in = skt_pkg::STATUS_OK;
            index_in  = skt_pkg::INDEX_BITS'(pos_ff);
            hout_in   = skt_pkg::HOUT_BITS'(rd_handle);
         end
         default: status_in = skt_pkg::STATUS_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         hout_ff   <= hout_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.index      = index_ff;
   assign rsp_ch.handle_out = hout_ff;

   assign stat.req_valid = req_ch.valid;
   assign stat.kind      = kind_ff;
   assign stat.full      = (count_ff == skt_pkg::COUNT_BITS'(skt_pkg::TABLE_DEPTH));
   assign stat.pos_ok    = (32'(pos_ff) < 32'(count_ff));
   assign stat.live      = (lo_ff < hi1_ff);
   assign stat.key_eq    = (rd_key == key_ff);
   assign stat.key_gt    = (rd_key > key_ff);
   assign stat.sh_live   = (sh_ff > lo_ff);
   assign stat.out_free  = ~rsp_valid_ff | rsp_ch.ready;

   `SKT_ASSERT(a_count_bound, count_ff <= skt_pkg::COUNT_BITS'(skt_pkg::TABLE_DEPTH), "entry count beyond table depth")
   `SKT_ASSERT(a_ins_not_full, !cmd.ins_wr || !stat.full, "insert write into a full table")
   `SKT_ASSERT(a_shift_above, !cmd.sh_wr || (sh_ff > lo_ff), "shift write at or below insert slot")
   `SKT_ASSERT_NEXT(a_res_shown, cmd.res_load, rsp_valid_ff, "loaded result not presented")

endmodule

>>> rtl/skt_ctrl.sv
module skt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  skt_pkg::stat_type  stat,
   output skt_pkg::cmd_type   cmd
);

   skt_pkg::state_type    state_ff, state_in;
   skt_pkg::res_kind_type res_kind_ff, res_kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= skt_pkg::ST_IDLE;
         res_kind_ff <= skt_pkg::RES_MISS;
      end else begin
         state_ff    <= state_in;
         res_kind_ff <= res_kind_in;
      end
   end

   // Next state
   always_comb begin
      state_in    = state_ff;
      res_kind_in = res_kind_ff;
      unique case (state_ff)
         skt_pkg::ST_IDLE: begin
            if (stat.req_valid) begin
               state_in = skt_pkg::ST_DECODE;
            end
         end
         skt_pkg::ST_DECODE: begin
            priority if (stat.kind == skt_pkg::KIND_INSERT) begin
               if (stat.full) begin
                  res_kind_in = skt_pkg::RES_FULL;
                  state_in    = skt_pkg::ST_DONE;
               end else begin
                  state_in = skt_pkg::ST_S_ADDR;
               end
            end else if (stat.kind == skt_pkg::KIND_LOOKUP) begin
               state_in = skt_pkg::ST_S_ADDR;
            end else if (stat.kind == skt_pkg::KIND_READ) begin
               if (stat.pos_ok) begin
                  state_in = skt_pkg::ST_POS_RD;
               end else begin
                  res_kind_in = skt_pkg::RES_RANGE;
                  state_in    = skt_pkg::ST_DONE;
               end
            end else begin
               res_kind_in = skt_pkg::RES_MISS;
               state_in    = skt_pkg::ST_DONE;
            end
         end
         skt_pkg::ST_S_ADDR: begin
            if (stat.live) begin
               state_in = skt_pkg::ST_S_CMP;
            end else if (stat.kind == skt_pkg::KIND_INSERT) begin
               state_in = skt_pkg::ST_SH_RD;
            end else begin
               res_kind_in = skt_pkg::RES_MISS;
               state_in    = skt_pkg::ST_DONE;
            end
         end
         skt_pkg::ST_S_CMP: begin
            if ((stat.kind == skt_pkg::KIND_LOOKUP) && stat.key_eq) begin
               res_kind_in = skt_pkg::RES_FOUND;
               state_in    = skt_pkg::ST_DONE;
            end else begin
               state_in = skt_pkg::ST_S_ADDR;
            end
         end
         skt_pkg::ST_SH_RD: begin
            state_in = stat.sh_live ? skt_pkg::ST_SH_WR : skt_pkg::ST_INS_WR;
         end
         skt_pkg::ST_SH_WR: state_in = skt_pkg::ST_SH_RD;
         skt_pkg::ST_INS_WR: begin
            res_kind_in = skt_pkg::RES_INSERTED;
            state_in    = skt_pkg::ST_DONE;
         end
         skt_pkg::ST_POS_RD: begin
            res_kind_in = skt_pkg::RES_READ;
            state_in    = skt_pkg::ST_DONE;
         end
         skt_pkg::ST_DONE: begin
            if (stat.out_free) begin
               state_in = skt_pkg::ST_IDLE;
            end
         end
         default: state_in = skt_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd          = '0;
      cmd.res_kind = res_kind_ff;
      unique case (state_ff)
         skt_pkg::ST_IDLE:   cmd.req_ready = 1'b1;
         skt_pkg::ST_DECODE: cmd.req_ready = 1'b0;
         skt_pkg::ST_S_ADDR: cmd.srch_rd   = stat.live;
         skt_pkg::ST_S_CMP:
            cmd.srch_step = !((stat.kind == skt_pkg::KIND_LOOKUP) && stat.key_eq);
         skt_pkg::ST_SH_RD:  cmd.sh_rd     = stat.sh_live;
         skt_pkg::ST_SH_WR:  cmd.sh_wr     = 1'b1;
         skt_pkg::ST_INS_WR: cmd.ins_wr    = 1'b1;
         skt_pkg::ST_POS_RD: cmd.pos_rd    = 1'b1;
         skt_pkg::ST_DONE:   cmd.res_load  = stat.out_free;
         default:            cmd.req_ready = 1'b0;
      endcase
   end

endmodule

>>> rtl/sorted_key_table.sv
// Sorted key table: (key, handle) pairs held in ascending key order in one
// single-port-read, single-port-write table memory.
// req_ch carries one item per transfer: insert, lookup by key, or read of the
// handle at a position. rsp_ch returns exactly one result per item, in order.
// One item is worked on at a time; req_ch.ready is high only while the block
// waits for work, and it may rise while the previous result still sits in the
// result register waiting for rsp_ch.ready.
// Work per item, with n entries in the table and s = number of search steps
// (at most ceil(log2(n+1))), one memory read each:
//   lookup: s steps, fewer on an early hit
//   insert: s steps, then m entries shifted up by one slot,
//           each shift a read and a write of the shared memory port pair
//   read by position: one memory read; refused items touch no memory.
// With a ready receiver, the next request transfer can happen at the edge
// where the previous result leaves.
// A stalled receiver holds the result register; the block finishes the next
// item and then waits until the register is free.
// Reset clears the entry count and the handshake state; the table memory
// needs no clearing pass, as only slots below the count are read.
module sorted_key_table (
   input  logic       clock,
   input  logic       reset,
   skt_req_if.sink    req_ch,
   skt_rsp_if.source  rsp_ch
);

   skt_pkg::cmd_type  cmd;
   skt_pkg::stat_type stat;

   skt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   skt_dpath u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .stat   (stat)
   );

endmodule

>>> tb/skt_checker.sv
module skt_checker (
   input  logic clock,
   input  logic reset,
   skt_req_if   req_ch,
   skt_rsp_if   rsp_ch,
   output int   mismatches,
   output int   answers_pending
);
   import skt_pkg::*;

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [INDEX_BITS-1:0]  index;
      logic [HOUT_BITS-1:0]   handle_out;
   } table_answer_type;

   logic [KEY_BITS-1:0]    key_mirror    [TABLE_DEPTH];
   logic [HANDLE_BITS-1:0] handle_mirror [TABLE_DEPTH];
   int                     entries;
   int                     results_seen;
   table_answer_type       answers_due [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t: result %0d: %s: got %0h, want %0h", $time, results_seen, what,
                  got, want);
      mismatches++;
   endtask

   // First slot whose key is strictly greater: equal keys stay in arrival order.
   function automatic int upper_slot(input logic [KEY_BITS-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = entries - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key_mirror[mid] > key) hi = mid - 1;
         else lo = mid + 1;
      end
      return lo;
   endfunction

   // First midpoint that hits during the search, -1 on a miss.
   function automatic int find_slot(input logic [KEY_BITS-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = entries - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (key_mirror[mid] == key) return mid;
         if (key_mirror[mid] > key) hi = mid - 1;
         else lo = mid + 1;
      end
      return -1;
   endfunction

   function automatic table_answer_type apply_item(input logic [KIND_BITS-1:0] kind,
                                                   input logic [KEY_BITS-1:0]  key,
                                                   input logic [HIN_BITS-1:0]  handle,
                                                   input logic [POS_BITS-1:0]  position);
      table_answer_type ans;
      int               slot;
      ans = '0;
      case (kind)
         KIND_INSERT: begin
            if (entries >= TABLE_DEPTH) begin
               ans.status = STATUS_FULL;
            end else begin
               slot = upper_slot(key);
               for (int i = entries; i > slot; i--) begin
                  key_mirror[i]    = key_mirror[i-1];
                  handle_mirror[i] = handle_mirror[i-1];
               end
               key_mirror[slot]    = key;
               handle_mirror[slot] = HANDLE_BITS'(handle);
               entries++;
               ans.status = STATUS_OK;
               ans.index  = INDEX_BITS'(slot);
            end
         end
         KIND_LOOKUP: begin
            slot = find_slot(key);
            if (slot < 0) begin
               ans.status = STATUS_MISS;
            end else begin
               ans.status     = STATUS_OK;
               ans.index      = INDEX_BITS'(slot);
               ans.handle_out = HOUT_BITS'(handle_mirror[slot]);
            end
         end
         KIND_READ: begin
            if (int'(position) >= entries) begin
               ans.status = STATUS_RANGE;
            end else begin
               ans.status     = STATUS_OK;
               ans.index      = INDEX_BITS'(position);
               ans.handle_out = HOUT_BITS'(handle_mirror[position]);
            end
         end
         default: begin
            ans.status = STATUS_MISS;
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      table_answer_type want;
      if (reset) begin
         entries      = 0;
         results_seen = 0;
         mismatches   = 0;
         answers_due.delete();
         answers_pending <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("result with no item outstanding",
                               32'({rsp_ch.status, rsp_ch.index, rsp_ch.handle_out}), '0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
               if (rsp_ch.index !== want.index)
                  report_mismatch("index", 32'(rsp_ch.index), 32'(want.index));
               if (rsp_ch.handle_out !== want.handle_out)
                  report_mismatch("handle_out", 32'(rsp_ch.handle_out),
                                  32'(want.handle_out));
            end
            results_seen++;
         end
         if (req_ch.valid && req_ch.ready)
            answers_due = {answers_due, apply_item(req_ch.kind, req_ch.key, req_ch.handle,
                                                   req_ch.position)};
         answers_pending <= answers_due.size();
      end
   end

endmodule

>>> tb/tb_top.sv
module tb_top;
   import skt_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 64;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   answers_pending;
   int   idle_cap = 10;
   int   items_sent = 0;
   int   quiet_cycles = 0;
   int   fill = 0;
   bit   hold_rsp = 1'b0;

   logic [KEY_BITS-1:0] stored_keys [$];
   logic [KEY_BITS-1:0] top_key;

   skt_req_if req_ch ();
   skt_rsp_if rsp_ch ();

   sorted_key_table i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   skt_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatches      (mismatches),
      .answers_pending (answers_pending)
   );

   always #4 clock = ~clock;

   task automatic send_item(input logic [KIND_BITS-1:0] kind,
                            input logic [KEY_BITS-1:0]  key,
                            input logic [HIN_BITS-1:0]  handle,
                            input logic [POS_BITS-1:0]  position);
      int gap;
      gap = $urandom_range(0, idle_cap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= kind;
      req_ch.key      <= key;
      req_ch.handle   <= handle;
      req_ch.position <= position;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (kind == KIND_INSERT && fill < TABLE_DEPTH) begin
         fill++;
         stored_keys = {stored_keys, key};
      end
      // switch between busy stretches and ones with random gaps
      items_sent++;
      if (items_sent % 40 == 0) idle_cap = ($urandom_range(0, 3) == 0) ? 0 : 10;
   endtask

   // Hold the sender until every outstanding result has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (answers_pending != 0);
   endtask

   function automatic logic [KEY_BITS-1:0] known_key();
      if (stored_keys.size() == 0) return $urandom();
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
   endfunction

   task automatic send_random_item();
      int                  pick;
      logic [KEY_BITS-1:0] key;
      logic [POS_BITS-1:0] position;
      pick     = $urandom_range(0, 99);
      key      = $urandom();
      position = $urandom();
      if (pick < 30) begin
         case ($urandom_range(0, 2))
            0: key = key & 32'h7FFF_FFFF;
            1: key = known_key();
            default: key = $urandom_range(0, 63);
         endcase
         send_item(KIND_INSERT, key, $urandom(), position);
      end else if (pick < 70) begin
         if ($urandom_range(0, 9) < 7) key = known_key();
         else if ($urandom_range(0, 1) == 0) key = $urandom_range(0, 63);
         send_item(KIND_LOOKUP, key, $urandom(), position);
      end else if (pick < 95) begin
         if (fill > 0 && $urandom_range(0, 9) < 8) position = $urandom_range(0, fill - 1);
         send_item(KIND_READ, key, $urandom(), position);
      end else begin
         send_item(KIND_SPARE, key, $urandom(), position);
      end
   endtask

   // Result side: random gaps per result, one long hold-off on request.
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, idle_cap);
         if (hold_rsp) begin
            gap      = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int pick;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.kind     <= KIND_INSERT;
      req_ch.key      <= '0;
      req_ch.handle   <= '0;
      req_ch.position <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table, odd kind, extremes and a run of equal keys
      send_item(KIND_LOOKUP, 32'h0000_0000, 16'h0000, 10'd0);
      send_item(KIND_READ,   32'h0000_0000, 16'h0000, 10'd0);
      send_item(KIND_SPARE,  32'hFFFF_FFFF, 16'hFFFF, 10'd1023);
      send_item(KIND_INSERT, 32'h0000_0000, 16'hFFFF, 10'd0);
      send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'h0000, 10'd0);
      send_item(KIND_INSERT, 32'h5555_AAAA, 16'hAAAA, 10'd0);
      send_item(KIND_INSERT, 32'h5555_AAAA, 16'h5555, 10'd0);
      send_item(KIND_INSERT, 32'h5555_AAAA, 16'h1234, 10'd0);
      send_item(KIND_LOOKUP, 32'h5555_AAAA, 16'h0000, 10'd0);
      send_item(KIND_LOOKUP, 32'h0000_0000, 16'h0000, 10'd0);
      send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 10'd0);
      send_item(KIND_LOOKUP, 32'h1234_5678, 16'h0000, 10'd0);
      send_item(KIND_LOOKUP, 32'hFFFF_FFFE, 16'h0000, 10'd0);
      send_item(KIND_INSERT, 32'h0000_0001, 16'h0F0F, 10'd0);
      send_item(KIND_READ,   32'h0000_0000, 16'h0000, 10'd0);
      send_item(KIND_READ,   32'h0000_0000, 16'h0000, 10'd5);
      send_item(KIND_READ,   32'h0000_0000, 16'h0000, 10'd6);
      send_item(KIND_READ,   32'h0000_0000, 16'h0000, 10'd1023);
      send_item(KIND_SPARE,  32'h0000_0000, 16'h0000, 10'd0);
      drain();

      // receiver holds off while items keep coming, so the input stalls
      hold_rsp = 1'b1;
      repeat (50) send_random_item();
      drain();
      repeat (50) send_random_item();
      drain();

      // fill to the top, mostly at the end of the table, a few deep shifts
      top_key = 32'h8000_0000 + $urandom_range(0, 255);
      while (fill < TABLE_DEPTH) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            top_key = top_key + $urandom_range(0, 2);
            send_item(KIND_INSERT, top_key, $urandom(), $urandom());
         end else if (pick < 90) begin
            send_item(KIND_INSERT, $urandom() & 32'h7FFF_FFFF, $urandom(), $urandom());
         end else begin
            send_random_item();
         end
      end
      drain();

      // full table: refused inserts, last slot
      send_item(KIND_INSERT, 32'h0000_0000, 16'hFFFF, 10'd0);
      send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'h0000, 10'd1023);
      send_item(KIND_INSERT, $urandom(), $urandom(), $urandom());
      send_item(KIND_READ,   32'h0000_0000, 16'h0000, 10'd1023);
      send_item(KIND_LOOKUP, top_key, 16'h0000, 10'd0);
      hold_rsp = 1'b1;
      repeat (75) send_random_item();
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && answers_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_req_if.sv
rtl/skt_rsp_if.sv
rtl/skt_dpath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table.sv
tb/skt_checker.sv
tb/tb_top.sv
